FILE: src/tbec_pkg.sv
package tbec_pkg;

  // magnitudes of centre and velocity differences fit in 32 bits
  localparam int MAG_W  = 32;
  localparam int PROD_W = 2 * MAG_W;
  // signed dot product of three terms, and its magnitude
  localparam int DOT_W  = PROD_W + 3;
  localparam int DEN_W  = PROD_W + 2;
  localparam int PMAG_W = DEN_W;
  // the numerator product is split in two halves of the dot magnitude
  localparam int HALF_W = PMAG_W / 2;
  localparam int PART_W = (PMAG_W - HALF_W) + MAG_W;
  localparam int NUM_W  = PMAG_W + MAG_W;
  // quotient bits, one per divider stage
  localparam int QBITS  = 34;
  localparam int REM_W  = DEN_W;
  localparam int SUM_W  = QBITS + 2;
  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    OP_PASS = 3'b001,
    OP_SWAP = 3'b010,
    OP_COLL = 3'b100
  } op_t;

  typedef struct packed {
    logic signed [31:0] vel1_x;
    logic signed [31:0] vel1_y;
    logic signed [31:0] vel1_z;
    logic signed [31:0] pos1_x;
    logic signed [31:0] pos1_y;
    logic signed [31:0] pos1_z;
    logic signed [31:0] vel2_x;
    logic signed [31:0] vel2_y;
    logic signed [31:0] vel2_z;
    logic signed [31:0] pos2_x;
    logic signed [31:0] pos2_y;
    logic signed [31:0] pos2_z;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] out_vel1_x;
    logic signed [31:0] out_vel1_y;
    logic signed [31:0] out_vel1_z;
    logic signed [31:0] out_vel2_x;
    logic signed [31:0] out_vel2_y;
    logic signed [31:0] out_vel2_z;
    logic               coincident;
  } resp_t;

  // classified pair as it travels from front to back
  typedef struct packed {
    op_t                   op;
    logic [2:0][31:0]      v1;
    logic [2:0][31:0]      v2;
    logic [2:0][MAG_W-1:0] mw;
    logic [2:0][MAG_W-1:0] md;
    logic [2:0]            sn;
    logic [2:0]            sd;
  } cls_item_t;

endpackage

FILE: src/two_body_elastic_collision.sv
// Equal-mass elastic collision response for streams of body pairs. One pair
// (two velocities, two centres, signed Q16.16) is taken per clock while the queue is
// not full, and one response leaves per clock while pop is held; a response passes
// through the queue, five arithmetic stages, the 35 registers of the
// 34-stage pipelined divider, rounding and the output register.
// A four-entry queue between the classifying front end and the arithmetic back
// end absorbs short stalls on either side. swap_tangential selects a full
// velocity swap; coinciding centres pass both velocities through and raise
// coincident. Write the mode only while no pair is in flight.
module two_body_elastic_collision (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tbec_pkg::pair_t   pair,
  output logic              empty,
  input  logic              pop,
  output tbec_pkg::resp_t   resp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import tbec_pkg::*;

  cls_item_t cls_item;
  cls_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  // classify incoming pairs
  tbec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cls_item  (cls_item)
  );

  // decoupling queue
  tbec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .valid   (q_valid)
  );

  // arithmetic back end
  tbec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .resp    (resp)
  );

endmodule

FILE: src/tbec_front.sv
module tbec_front (
  input  logic              clk,
  input  logic              rst,
  input  tbec_pkg::pair_t   pair,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output tbec_pkg::cls_item_t cls_item
);
  import tbec_pkg::*;

  logic                swap_tangential;
  logic [2:0][31:0]    v1;
  logic [2:0][31:0]    v2;
  logic [2:0][31:0]    p1;
  logic [2:0][31:0]    p2;
  logic [2:0][32:0]    d;
  logic [2:0][32:0]    w;
  logic [2:0][32:0]    dn;
  logic [2:0][32:0]    wn;
  logic                same;

  // mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_tangential <= 1'b0;
    end else if (cfg_valid) begin
      swap_tangential <= cfg_data;
    end
  end

  assign v1 = {pair.vel1_z, pair.vel1_y, pair.vel1_x};
  assign v2 = {pair.vel2_z, pair.vel2_y, pair.vel2_x};
  assign p1 = {pair.pos1_z, pair.pos1_y, pair.pos1_x};
  assign p2 = {pair.pos2_z, pair.pos2_y, pair.pos2_x};

  // axis and relative velocity, split into magnitude and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]  = {p2[i][31], p2[i]} - {p1[i][31], p1[i]};
      w[i]  = {v2[i][31], v2[i]} - {v1[i][31], v1[i]};
      dn[i] = d[i][32] ? (33'd0 - d[i]) : d[i];
      wn[i] = w[i][32] ? (33'd0 - w[i]) : w[i];
    end
  end

  assign same = (d == '0);

  // classify
  always_comb begin
    cls_item.v1 = v1;
    cls_item.v2 = v2;
    for (int i = 0; i < 3; i++) begin
      cls_item.md[i] = dn[i][MAG_W-1:0];
      cls_item.mw[i] = wn[i][MAG_W-1:0];
      cls_item.sd[i] = d[i][32];
      cls_item.sn[i] = d[i][32] ^ w[i][32];
    end
    if (same) begin
      cls_item.op = OP_PASS;
    end else if (swap_tangential) begin
      cls_item.op = OP_SWAP;
    end else begin
      cls_item.op = OP_COLL;
    end
  end

endmodule

FILE: src/tbec_queue.sv
module tbec_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  tbec_pkg::cls_item_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output tbec_pkg::cls_item_t rd_data,
  output logic                valid
);
  import tbec_pkg::*;

  cls_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              wr;
  logic              rd;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign valid   = (count != '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && valid;
  assign rd_data = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/tbec_back.sv
module tbec_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tbec_pkg::cls_item_t q_item,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output tbec_pkg::resp_t     resp
);
  import tbec_pkg::*;

  typedef struct packed {
    op_t              op;
    logic [2:0][31:0] v1;
    logic [2:0][31:0] v2;
    logic [2:0]       sd;
  } ctx_t;

  logic en;

  // stage 1: products
  logic                   s1_v;
  ctx_t                   s1_ctx;
  logic [2:0][PROD_W-1:0] s1_p;
  logic [2:0][PROD_W-1:0] s1_dd;
  logic [2:0]             s1_sn;
  logic [2:0][MAG_W-1:0]  s1_md;
  // stage 2: dot product and squared distance
  logic                   s2_v;
  ctx_t                   s2_ctx;
  logic [DOT_W-1:0]       s2_dot;
  logic [DEN_W-1:0]       s2_den;
  logic [2:0][MAG_W-1:0]  s2_md;
  logic [2:0][DOT_W-1:0]  term;
  // stage 3: magnitude of the dot product
  logic                   s3_v;
  ctx_t                   s3_ctx;
  logic [PMAG_W-1:0]      s3_pmag;
  logic                   s3_pneg;
  logic [DEN_W-1:0]       s3_den;
  logic [2:0][MAG_W-1:0]  s3_md;
  // stage 4: partial products of the numerators
  logic                   s4_v;
  ctx_t                   s4_ctx;
  logic [2:0][PART_W-1:0] s4_plo;
  logic [2:0][PART_W-1:0] s4_phi;
  logic                   s4_pneg;
  logic [DEN_W-1:0]       s4_den;
  // stage 5: numerators
  logic                   s5_v;
  ctx_t                   s5_ctx;
  logic [2:0][NUM_W-1:0]  s5_num;
  logic                   s5_pneg;
  logic [DEN_W-1:0]       s5_den;
  // divider stages
  logic                   dv_v    [QBITS+1];
  ctx_t                   dv_ctx  [QBITS+1];
  logic [DEN_W-1:0]       dv_den  [QBITS+1];
  logic                   dv_pneg [QBITS+1];
  logic [2:0][REM_W-1:0]  dv_rem  [QBITS+1];
  logic [2:0][QBITS-1:0]  dv_low  [QBITS+1];
  logic [2:0][QBITS-1:0]  dv_q    [QBITS+1];
  logic [2:0][REM_W:0]    st_cat  [QBITS];
  logic [2:0][REM_W-1:0]  st_rem  [QBITS];
  logic [2:0]             st_ge   [QBITS];
  // rounding stage
  logic                   r_v;
  ctx_t                   r_ctx;
  logic                   r_pneg;
  logic [2:0][QBITS:0]    r_q;
  // output register
  logic                   o_valid;
  resp_t                  o_item;
  logic [2:0][SUM_W-1:0]  delta;
  logic [2:0][SUM_W-1:0]  sum1;
  logic [2:0][SUM_W-1:0]  sum2;
  logic [2:0][31:0]       n1;
  logic [2:0][31:0]       n2;
  resp_t                  o_next;

  function automatic logic [31:0] sat(input logic [SUM_W-1:0] x);
    if (x[SUM_W-1:31] == '0 || x[SUM_W-1:31] == '1) begin
      return x[31:0];
    end else if (x[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  // the whole back end moves while the output slot frees up
  assign en    = !o_valid || pop;
  assign q_pop = en && q_valid;
  assign empty = !o_valid;
  assign resp  = o_item;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_v    <= 1'b0;
      s5_v    <= 1'b0;
      dv_v    <= '{default: 1'b0};
      r_v     <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= q_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      dv_v[0]   <= s5_v;
      for (int k = 0; k < QBITS; k++) begin
        dv_v[k+1] <= dv_v[k];
      end
      r_v       <= dv_v[QBITS];
      o_valid   <= r_v;
    end
  end

  // signed terms of the dot product
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      term[l] = s1_sn[l] ? (DOT_W'(0) - DOT_W'(s1_p[l])) : DOT_W'(s1_p[l]);
    end
  end

  // stages 1 to 5
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx <= '{op: q_item.op, v1: q_item.v1, v2: q_item.v2, sd: q_item.sd};
      s1_sn  <= q_item.sn;
      s1_md  <= q_item.md;
      for (int l = 0; l < 3; l++) begin
        s1_p[l]  <= PROD_W'(q_item.mw[l]) * PROD_W'(q_item.md[l]);
        s1_dd[l] <= PROD_W'(q_item.md[l]) * PROD_W'(q_item.md[l]);
      end

      s2_ctx <= s1_ctx;
      s2_md  <= s1_md;
      s2_dot <= term[0] + term[1] + term[2];
      s2_den <= DEN_W'(s1_dd[0]) + DEN_W'(s1_dd[1]) + DEN_W'(s1_dd[2]);

      s3_ctx  <= s2_ctx;
      s3_md   <= s2_md;
      s3_den  <= s2_den;
      s3_pneg <= s2_dot[DOT_W-1];
      s3_pmag <= s2_dot[DOT_W-1] ? PMAG_W'(DOT_W'(0) - s2_dot) : PMAG_W'(s2_dot);

      s4_ctx  <= s3_ctx;
      s4_den  <= s3_den;
      s4_pneg <= s3_pneg;
      for (int l = 0; l < 3; l++) begin
        s4_plo[l] <= PART_W'(s3_pmag[HALF_W-1:0]) * PART_W'(s3_md[l]);
        s4_phi[l] <= PART_W'(s3_pmag[PMAG_W-1:HALF_W]) * PART_W'(s3_md[l]);
      end

      s5_ctx  <= s4_ctx;
      s5_den  <= s4_den;
      s5_pneg <= s4_pneg;
      for (int l = 0; l < 3; l++) begin
        s5_num[l] <= NUM_W'(s4_plo[l]) + (NUM_W'(s4_phi[l]) << HALF_W);
      end
    end
  end

  // one restoring division step per stage and lane
  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      for (int l = 0; l < 3; l++) begin
        st_cat[k][l] = {dv_rem[k][l], dv_low[k][l][QBITS-1]};
        st_ge[k][l]  = (st_cat[k][l] >= {1'b0, dv_den[k]});
        st_rem[k][l] = st_ge[k][l] ? REM_W'(st_cat[k][l] - {1'b0, dv_den[k]})
                                   : st_cat[k][l][REM_W-1:0];
      end
    end
  end

  // divider pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctx[0]  <= s5_ctx;
      dv_den[0]  <= s5_den;
      dv_pneg[0] <= s5_pneg;
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= REM_W'(s5_num[l][NUM_W-1:QBITS]);
        dv_low[0][l] <= s5_num[l][QBITS-1:0];
        dv_q[0][l]   <= '0;
      end
      for (int k = 0; k < QBITS; k++) begin
        dv_ctx[k+1]  <= dv_ctx[k];
        dv_den[k+1]  <= dv_den[k];
        dv_pneg[k+1] <= dv_pneg[k];
        for (int l = 0; l < 3; l++) begin
          dv_rem[k+1][l] <= st_rem[k][l];
          dv_low[k+1][l] <= {dv_low[k][l][QBITS-2:0], 1'b0};
          dv_q[k+1][l]   <= {dv_q[k][l][QBITS-2:0], st_ge[k][l]};
        end
      end
    end
  end

  // round half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      r_ctx  <= dv_ctx[QBITS];
      r_pneg <= dv_pneg[QBITS];
      for (int l = 0; l < 3; l++) begin
        r_q[l] <= (QBITS+1)'(dv_q[QBITS][l])
                + (QBITS+1)'({dv_rem[QBITS][l], 1'b0} >= {1'b0, dv_den[QBITS]});
      end
    end
  end

  // apply the exchange and saturate, or pass or swap the velocities
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      delta[l] = (r_pneg ^ r_ctx.sd[l]) ? (SUM_W'(0) - SUM_W'(r_q[l]))
                                        : SUM_W'(r_q[l]);
      sum1[l]  = SUM_W'($signed(r_ctx.v1[l])) + delta[l];
      sum2[l]  = SUM_W'($signed(r_ctx.v2[l])) - delta[l];
      unique case (r_ctx.op)
        OP_PASS: begin
          n1[l] = r_ctx.v1[l];
          n2[l] = r_ctx.v2[l];
        end
        OP_SWAP: begin
          n1[l] = r_ctx.v2[l];
          n2[l] = r_ctx.v1[l];
        end
        default: begin
          n1[l] = sat(sum1[l]);
          n2[l] = sat(sum2[l]);
        end
      endcase
    end
    o_next.out_vel1_x = n1[0];
    o_next.out_vel1_y = n1[1];
    o_next.out_vel1_z = n1[2];
    o_next.out_vel2_x = n2[0];
    o_next.out_vel2_y = n2[1];
    o_next.out_vel2_z = n2[2];
    o_next.coincident = (r_ctx.op == OP_PASS);
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      o_item <= o_next;
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tbec_pkg::*;

  logic  clk;
  logic  rst;
  logic  push;
  logic  full;
  pair_t pair;
  logic  empty;
  logic  pop;
  resp_t resp;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  resp_t expected_resps[$];
  bit    swap_mode;
  int    errors;
  int    hold_cycles;
  bit    rx_idle_off;

  two_body_elastic_collision dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pair      (pair),
    .empty     (empty),
    .pop       (pop),
    .resp      (resp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // velocities after collision for one pair
  function automatic resp_t collide(pair_t p, bit swap);
    resp_t r;
    logic signed [127:0] v1[3], v2[3], d[3], w[3], dot, den, pmag, num, q, rem, ad, delta;
    bit same;
    bit pneg;
    v1[0] = p.vel1_x; v1[1] = p.vel1_y; v1[2] = p.vel1_z;
    v2[0] = p.vel2_x; v2[1] = p.vel2_y; v2[2] = p.vel2_z;
    d[0] = 128'(signed'(p.pos2_x)) - 128'(signed'(p.pos1_x));
    d[1] = 128'(signed'(p.pos2_y)) - 128'(signed'(p.pos1_y));
    d[2] = 128'(signed'(p.pos2_z)) - 128'(signed'(p.pos1_z));
    same = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
    dot = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = v2[i] - v1[i];
      dot = dot + w[i] * d[i];
      den = den + d[i] * d[i];
    end
    r.coincident = same;
    if (same || swap) begin
      r.out_vel1_x = same ? p.vel1_x : p.vel2_x;
      r.out_vel1_y = same ? p.vel1_y : p.vel2_y;
      r.out_vel1_z = same ? p.vel1_z : p.vel2_z;
      r.out_vel2_x = same ? p.vel2_x : p.vel1_x;
      r.out_vel2_y = same ? p.vel2_y : p.vel1_y;
      r.out_vel2_z = same ? p.vel2_z : p.vel1_z;
      return r;
    end
    pneg = dot < 0;
    pmag = pneg ? -dot : dot;
    for (int i = 0; i < 3; i++) begin
      ad = (d[i] < 0) ? -d[i] : d[i];
      num = pmag * ad;
      q = num / den;
      rem = num % den;
      // round to nearest, ties away from zero
      if (2 * rem >= den) q = q + 1;
      delta = (pneg != (d[i] < 0)) ? -q : q;
      v1[i] = v1[i] + delta;
      v2[i] = v2[i] - delta;
    end
    r.out_vel1_x = sat32(v1[0]); r.out_vel1_y = sat32(v1[1]); r.out_vel1_z = sat32(v1[2]);
    r.out_vel2_x = sat32(v2[0]); r.out_vel2_y = sat32(v2[1]); r.out_vel2_z = sat32(v2[2]);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random field value: extremes, small values or full range
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.vel1_x = rand_q16(); p.vel1_y = rand_q16(); p.vel1_z = rand_q16();
    p.vel2_x = rand_q16(); p.vel2_y = rand_q16(); p.vel2_z = rand_q16();
    p.pos1_x = rand_q16(); p.pos1_y = rand_q16(); p.pos1_z = rand_q16();
    case ($urandom_range(0, 9))
      // coinciding centres
      0: begin
        p.pos2_x = p.pos1_x; p.pos2_y = p.pos1_y; p.pos2_z = p.pos1_z;
      end
      // centres differing on a single axis
      1: begin
        p.pos2_x = p.pos1_x; p.pos2_y = p.pos1_y; p.pos2_z = rand_q16();
      end
      default: begin
        p.pos2_x = rand_q16(); p.pos2_y = rand_q16(); p.pos2_z = rand_q16();
      end
    endcase
    return p;
  endfunction

  // offer one pair and wait for its transfer
  task automatic send_pair(pair_t p, bit idle);
    int gap;
    gap = idle ? gap_len() : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    pair = p;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_resps.push_back(collide(p, swap_mode));
    @(negedge clk);
  endtask

  // wait until every response is in, then write the mode
  task automatic write_mode(bit m);
    push = 1'b0;
    while (expected_resps.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    swap_mode = m;
  endtask

  // receiver: random pop at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_cycles > 0) begin
      pop = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (rx_idle_off) begin
      pop = 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          pop = 1'b0;
          hold_cycles = $urandom_range(10, 40);
        end
        1, 2, 3, 4: pop = 1'b0;
        default: pop = 1'b1;
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // response check on each transfer
  always @(posedge clk) begin
    resp_t e;
    if (!rst && pop && !empty) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected response: expected none actual %h", $time, resp);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        check_field("out_vel1_x", e.out_vel1_x, resp.out_vel1_x);
        check_field("out_vel1_y", e.out_vel1_y, resp.out_vel1_y);
        check_field("out_vel1_z", e.out_vel1_z, resp.out_vel1_z);
        check_field("out_vel2_x", e.out_vel2_x, resp.out_vel2_x);
        check_field("out_vel2_y", e.out_vel2_y, resp.out_vel2_y);
        check_field("out_vel2_z", e.out_vel2_z, resp.out_vel2_z);
        check_field("coincident", 32'(e.coincident), 32'(resp.coincident));
      end
    end
  end

  task automatic make_pair(output pair_t p, input logic signed [31:0] v1, v2, c1, c2);
    p = '{v1, v1, v1, c1, c1, c1, v2, v2, v2, c2, c2, c2};
  endtask

  // extremes, coinciding centres and single-axis hits
  task automatic test_directed();
    pair_t p;
    make_pair(p, 0, 0, 0, 0);                                        send_pair(p, 0);
    make_pair(p, 32'sh7fffffff, 32'sh80000000, 5, 5);                send_pair(p, 0);
    make_pair(p, 32'sh7fffffff, 32'sh80000000, 0, 32'sh0001_0000);   send_pair(p, 0);
    make_pair(p, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff); send_pair(p, 0);
    make_pair(p, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000); send_pair(p, 0);
    make_pair(p, 32'sh0001_0000, -32'sh0001_0000, 0, 1);             send_pair(p, 0);
    make_pair(p, -1, -1, -1, -1);                                    send_pair(p, 0);
    p = '{32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 0, 0, 0, 0, 32'sh0001_0000, 0, 0};
    send_pair(p, 0);
    p = '{32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 3, 3, 1};
    send_pair(p, 0);
    p = '{32'sh7fffffff, 32'sh80000000, 1, 32'sh80000000, 0, 32'sh7fffffff,
          32'sh80000000, 32'sh7fffffff, -1, 32'sh7fffffff, 0, 32'sh80000000};
    send_pair(p, 1);
    // three of the same items in swap mode
    write_mode(1'b1);
    make_pair(p, 32'sh7fffffff, 32'sh80000000, 0, 32'sh0001_0000);   send_pair(p, 0);
    make_pair(p, 32'sh7fffffff, 32'sh80000000, 5, 5);                send_pair(p, 0);
    make_pair(p, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff); send_pair(p, 0);
    write_mode(1'b0);
  endtask

  // long receiver stall while pairs keep arriving
  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 300;
    repeat (80) send_pair(rand_pair(), 0);
  endtask

  // random pairs over several mode settings
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      rx_idle_off = (ph == 2);
      repeat (200) send_pair(rand_pair(), ph != 3);
    end
    rx_idle_off = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pair = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    swap_mode = 1'b0;
    errors = 0;
    hold_cycles = 0;
    rx_idle_off = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    push = 1'b0;
    while (expected_resps.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/tbec_pkg.sv
src/tbec_front.sv
src/tbec_queue.sv
src/tbec_back.sv
src/two_body_elastic_collision.sv
test/tb.sv
